>>> src/ggte_pkg.sv
`timescale 1ns / 1ps

package ggte_pkg;

    // Register map of the configuration port
    localparam logic [2:0] REG_HASH_KEY_HIGH = 3'd0;
    localparam logic [2:0] REG_HASH_KEY_LOW  = 3'd1;
    localparam logic [2:0] REG_MASK_HIGH     = 3'd2;
    localparam logic [2:0] REG_MASK_LOW      = 3'd3;
    localparam logic [2:0] REG_TAG_BYTES     = 3'd4;

    localparam int          BLOCK_BYTES   = 16;
    localparam logic [7:0]  GF_POLY       = 8'hE1;
    localparam logic [4:0]  TAG_BYTES_MIN = 5'd4;
    localparam logic [4:0]  TAG_BYTES_MAX = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_LEN,
        ST_MUL
    } state_t;

    // Multiply by x in GCM bit order: shift toward the low end, fold the dropped bit
    function automatic logic [127:0] gf_mulx(input logic [127:0] v);
        logic [127:0] r;
        r = v >> 1;
        if (v[0])
        begin
            r[127:120] = r[127:120] ^ GF_POLY;
        end
        return r;
    endfunction

    function automatic logic [127:0] gf_mulx8(input logic [127:0] v);
        logic [127:0] r;
        r = v;
        for (int i = 0; i < 8; i++)
        begin
            r = gf_mulx(r);
        end
        return r;
    endfunction

endpackage

>>> src/gmac_ghash_tag_engine.sv
`timescale 1ns / 1ps

// Channel   | Dir | Word                         | Side bits
// s_axis    | in  | tdata[7:0] = data_byte       | tuser[0] = has_byte, tlast = final_item
// m_axis    | out | tdata[63:0] = tag_word       | tuser[0] = word_index, tlast = last_word
// cfg       | in  | cfg_data = register value    | cfg_we, cfg_index selects the register
//
// A message byte is taken in the idle state; each completed 16-byte block adds a load step and
// a pass through the byte-digit GF(2^128) multiplier, which sets the sustained rate.
// A final word adds zero padding of a partial block and the length block multiply, then the two
// tag words leave through an output register; the next message may start meanwhile.
// Reset clears the hash state and sets tag_bytes to 16. The input stalls while a
// multiply runs; a stalled output only holds the next length block from starting.
module gmac_ghash_tag_engine
    import ggte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] tag_word
    output logic [0:0]  m_axis_tuser,   // [0] word_index
    output logic        m_axis_tlast,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    state_t         state_reg, state_next;
    logic [127:0]   acc_reg, acc_next;
    logic [127:0]   blk_reg, blk_next;
    logic [127:0]   opnd_reg, opnd_next;
    logic [127:0]   tag_reg, tag_next;
    logic [3:0]     fill_reg, fill_next;
    logic [60:0]    total_reg, total_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic           fin_pend_reg, fin_pend_next;
    logic           len_phase_reg, len_phase_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_sel_reg, out_sel_next;

    logic [63:0]    hkey_high_reg, hkey_low_reg;
    logic [63:0]    mask_high_reg, mask_low_reg;
    logic [4:0]     tag_bytes_reg;

    logic           in_acc;
    logic           out_acc;
    logic [4:0]     fill_inc;
    logic           blk_full;
    logic           mul_done;
    logic [127:0]   hx [8];
    logic [127:0]   z_step;
    logic [4:0]     keep_n;
    logic [127:0]   keep;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_acc  = m_axis_tvalid && m_axis_tready;
    assign fill_inc = {1'b0, fill_reg} + {4'd0, s_axis_tuser[0]};
    assign blk_full = (fill_inc == 5'(BLOCK_BYTES));
    assign mul_done = (cnt_reg == 4'(BLOCK_BYTES - 1));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hkey_high_reg <= '0;
            hkey_low_reg  <= '0;
            mask_high_reg <= '0;
            mask_low_reg  <= '0;
            tag_bytes_reg <= TAG_BYTES_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HASH_KEY_HIGH: hkey_high_reg <= cfg_data;
                REG_HASH_KEY_LOW:  hkey_low_reg  <= cfg_data;
                REG_MASK_HIGH:     mask_high_reg <= cfg_data;
                REG_MASK_LOW:      mask_low_reg  <= cfg_data;
                REG_TAG_BYTES:     tag_bytes_reg <= cfg_data[4:0];
                default:           ;
            endcase
        end
    end

    // H times x^k for the eight bit positions of a digit
    always_comb
    begin
        hx[0] = {hkey_high_reg, hkey_low_reg};
        for (int k = 1; k < 8; k++)
        begin
            hx[k] = gf_mulx(hx[k-1]);
        end
    end

    // One Horner step: Z * x^8 plus the lowest operand byte times H
    always_comb
    begin
        z_step = gf_mulx8(acc_reg);
        for (int k = 0; k < 8; k++)
        begin
            if (opnd_reg[7-k])
            begin
                z_step = z_step ^ hx[k];
            end
        end
    end

    // Byte enables of the kept tag bytes, first tag byte at the top
    always_comb
    begin
        priority if (tag_bytes_reg < TAG_BYTES_MIN)
            keep_n = TAG_BYTES_MIN;
        else if (tag_bytes_reg > TAG_BYTES_MAX)
            keep_n = TAG_BYTES_MAX;
        else
            keep_n = tag_bytes_reg;
        for (int j = 0; j < BLOCK_BYTES; j++)
        begin
            keep[127 - 8*j -: 8] = (5'(j) < keep_n) ? 8'hFF : 8'h00;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (blk_full)
                        state_next = ST_LOAD;
                    else if (s_axis_tlast && (fill_inc != 5'd0))
                        state_next = ST_PAD;
                    else if (s_axis_tlast)
                        state_next = ST_LEN;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == 4'(BLOCK_BYTES - 1))
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_MUL;
            end
            ST_LEN:
            begin
                if (!out_valid_reg)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    priority if (len_phase_reg)
                        state_next = ST_IDLE;
                    else if (fin_pend_reg)
                        state_next = ST_LEN;
                    else
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata  = out_sel_reg ? tag_reg[63:0] : tag_reg[127:64];
        m_axis_tuser  = out_sel_reg;
        m_axis_tlast  = out_sel_reg;
    end

    // Datapath
    always_comb
    begin
        acc_next       = acc_reg;
        blk_next       = blk_reg;
        opnd_next      = opnd_reg;
        tag_next       = tag_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        cnt_next       = cnt_reg;
        fin_pend_next  = fin_pend_reg;
        len_phase_next = len_phase_reg;
        out_valid_next = out_valid_reg;
        out_sel_next   = out_sel_reg;

        if (out_acc)
        begin
            if (out_sel_reg)
            begin
                out_valid_next = 1'b0;
                out_sel_next   = 1'b0;
            end
            else
            begin
                out_sel_next = 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_axis_tuser[0])
                    begin
                        blk_next   = {blk_reg[119:0], s_axis_tdata};
                        total_next = total_reg + 61'd1;
                    end
                    fill_next     = blk_full ? 4'd0 : fill_inc[3:0];
                    fin_pend_next = s_axis_tlast;
                end
            end
            ST_PAD:
            begin
                // pad the partial block with zero bytes, one per cycle
                blk_next  = {blk_reg[119:0], 8'h00};
                fill_next = fill_reg + 4'd1;
            end
            ST_LOAD:
            begin
                opnd_next      = acc_reg ^ blk_reg;
                acc_next       = '0;
                cnt_next       = '0;
                len_phase_next = 1'b0;
            end
            ST_LEN:
            begin
                if (!out_valid_reg)
                begin
                    opnd_next      = acc_reg ^ {total_reg, 3'b000, 64'd0};
                    acc_next       = '0;
                    cnt_next       = '0;
                    len_phase_next = 1'b1;
                end
            end
            ST_MUL:
            begin
                acc_next  = z_step;
                opnd_next = opnd_reg >> 8;
                cnt_next  = cnt_reg + 4'd1;
                if (mul_done && len_phase_reg)
                begin
                    tag_next       = (z_step ^ {mask_high_reg, mask_low_reg}) & keep;
                    out_valid_next = 1'b1;
                    out_sel_next   = 1'b0;
                    // drop the message state for the next run
                    acc_next       = '0;
                    total_next     = '0;
                    fin_pend_next  = 1'b0;
                    len_phase_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            cnt_reg       <= '0;
            fin_pend_reg  <= 1'b0;
            len_phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            cnt_reg       <= cnt_next;
            fin_pend_reg  <= fin_pend_next;
            len_phase_reg <= len_phase_next;
            out_valid_reg <= out_valid_next;
            out_sel_reg   <= out_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        opnd_reg <= opnd_next;
        tag_reg  <= tag_next;
    end

`ifndef NO_ASSERTIONS
    a_tag_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && mul_done && len_phase_reg) |-> !out_valid_reg)
        else $error("tag register loaded while previous tag still pending");

    a_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_LOAD) |-> (fill_reg == 4'd0))
        else $error("multiply running with a partly filled block");

    a_tag_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("new tag appeared right after the last tag word");
`endif

endmodule

>>> dv/gmac_tag_checker.sv
`timescale 1ns / 1ps

module gmac_tag_checker
    import ggte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,   // [63:0] tag_word
    input  logic [0:0]  m_axis_tuser,   // [0] word_index
    input  logic        m_axis_tlast,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,

    output int          fail_count,
    output int          tags_pending,
    output int          words_checked
);

    typedef struct packed {
        logic [63:0] tag_word;
        logic        word_index;
        logic        last_word;
    } tag_word_t;

    tag_word_t      expected_tags[$];

    // Predicted engine state
    logic [127:0]   hash_subkey;
    logic [127:0]   tag_mask;
    logic [4:0]     tag_len;
    logic [127:0]   ghash_acc;
    logic [7:0]     block_bytes[16];
    logic [4:0]     fill;
    logic [60:0]    msg_bytes;

    int             mismatches;
    int             seen;

    assign fail_count    = mismatches;
    assign words_checked = seen;

    // GF(2^128) product in GCM bit order: bit 127 is the coefficient of x^0
    function automatic logic [127:0] gf128_mul(input logic [127:0] x, input logic [127:0] h);
        logic [127:0] z;
        logic [127:0] v;
        logic         carry;
        z = '0;
        v = h;
        for (int i = 0; i < 128; i++)
        begin
            if (x[127 - i])
            begin
                z = z ^ v;
            end
            carry = v[0];
            v = v >> 1;
            if (carry)
            begin
                v[127:120] = v[127:120] ^ GF_POLY;
            end
        end
        return z;
    endfunction

    // Fold the first count bytes of the block, zero-padded, into the hash
    task automatic absorb_block(input int count);
        logic [127:0] blk;
        blk = '0;
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            if (i < count)
            begin
                blk[127 - 8 * i -: 8] = block_bytes[i];
            end
        end
        ghash_acc = gf128_mul(ghash_acc ^ blk, hash_subkey);
    endtask

    function automatic logic [63:0] byte_keep(input int nbytes);
        if (nbytes <= 0)
        begin
            return 64'h0;
        end
        if (nbytes >= 8)
        begin
            return '1;
        end
        return ~64'h0 << (64 - 8 * nbytes);
    endfunction

    task automatic clear_message();
        ghash_acc = '0;
        fill      = '0;
        msg_bytes = '0;
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            block_bytes[i] = 8'h00;
        end
    endtask

    task automatic finish_tag();
        int          n;
        tag_word_t   w;
        logic [63:0] t0;
        logic [63:0] t1;
        if (fill > 0)
        begin
            absorb_block(int'(fill));
        end
        ghash_acc[127:64] = ghash_acc[127:64] ^ {msg_bytes, 3'b000};
        ghash_acc = gf128_mul(ghash_acc, hash_subkey);
        n = int'(tag_len);
        if (n < int'(TAG_BYTES_MIN))
        begin
            n = int'(TAG_BYTES_MIN);
        end
        if (n > int'(TAG_BYTES_MAX))
        begin
            n = int'(TAG_BYTES_MAX);
        end
        t0 = (ghash_acc[127:64] ^ tag_mask[127:64]) & byte_keep(n);
        t1 = (ghash_acc[63:0] ^ tag_mask[63:0]) & byte_keep(n - 8);
        w.tag_word   = t0;
        w.word_index = 1'b0;
        w.last_word  = 1'b0;
        expected_tags.push_back(w);
        w.tag_word   = t1;
        w.word_index = 1'b1;
        w.last_word  = 1'b1;
        expected_tags.push_back(w);
        clear_message();
    endtask

    task automatic compare_word();
        tag_word_t exp_w;
        seen++;
        if (expected_tags.size() == 0)
        begin
            $error("tag word with no expectation: tag_word %h word_index %0d last_word %0d",
                   m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
            mismatches++;
            return;
        end
        exp_w = expected_tags.pop_front();
        if (m_axis_tdata !== exp_w.tag_word)
        begin
            $error("tag_word mismatch: expected %h, got %h", exp_w.tag_word, m_axis_tdata);
            mismatches++;
        end
        if (m_axis_tuser[0] !== exp_w.word_index)
        begin
            $error("word_index mismatch: expected %0d, got %0d",
                   exp_w.word_index, m_axis_tuser[0]);
            mismatches++;
        end
        if (m_axis_tlast !== exp_w.last_word)
        begin
            $error("last_word mismatch: expected %0d, got %0d", exp_w.last_word, m_axis_tlast);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_subkey = '0;
            tag_mask    = '0;
            tag_len     = TAG_BYTES_MAX;
            mismatches  = 0;
            seen        = 0;
            expected_tags.delete();
            clear_message();
            tags_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HASH_KEY_HIGH: hash_subkey[127:64] = cfg_data;
                    REG_HASH_KEY_LOW:  hash_subkey[63:0]   = cfg_data;
                    REG_MASK_HIGH:     tag_mask[127:64]    = cfg_data;
                    REG_MASK_LOW:      tag_mask[63:0]      = cfg_data;
                    REG_TAG_BYTES:     tag_len             = cfg_data[4:0];
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                compare_word();
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0])
                begin
                    block_bytes[fill[3:0]] = s_axis_tdata;
                    fill      = fill + 5'd1;
                    msg_bytes = msg_bytes + 61'd1;
                    if (fill >= 5'(BLOCK_BYTES))
                    begin
                        absorb_block(BLOCK_BYTES);
                        fill = '0;
                    end
                end
                if (s_axis_tlast)
                begin
                    finish_tag();
                end
            end

            tags_pending <= expected_tags.size();
        end
    end

endmodule

>>> dv/tb_gmac_ghash_tag_engine.sv
`timescale 1ns / 1ps

module tb_gmac_ghash_tag_engine;
    import ggte_pkg::*;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_TX,
        IDLE_RX,
        IDLE_BOTH
    } idle_mode_t;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 2500;
    localparam int SETTLE       = 64;
    localparam int PHASE_QUOTA  = 165;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic [0:0]  s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_HASH_KEY_HIGH;
    logic [63:0] cfg_data = 64'h0;

    idle_mode_t  idle_mode = IDLE_NONE;
    logic        hold_req = 1'b0;
    int          hold_count = 0;
    int          cycle_count = 0;
    int          words_sent = 0;
    int          messages = 0;

    int          fail_count;
    int          tags_pending;
    int          words_checked;

    gmac_ghash_tag_engine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    gmac_tag_checker u_tag_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .tags_pending  (tags_pending),
        .words_checked (words_checked)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: a long hold-off once requested, otherwise random stalls per phase
    always @(posedge clk)
    begin
        if (hold_req && hold_count < HOLD_CYCLES)
        begin
            m_axis_tready <= 1'b0;
            hold_count    <= hold_count + 1;
        end
        else
        begin
            case (idle_mode)
                IDLE_RX:   m_axis_tready <= ($urandom_range(0, 99) >= 76);
                IDLE_BOTH: m_axis_tready <= ($urandom_range(0, 99) >= 8);
                default:   m_axis_tready <= 1'b1;
            endcase
        end
    end

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_TX:   return $urandom_range(0, 99) < 76;
            IDLE_BOTH: return $urandom_range(0, 99) < 8;
            default:   return 1'b0;
        endcase
    endfunction

    task automatic send_word(input logic [7:0] data, input logic has_byte, input logic fin);
        while (sender_idles())
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= data;
        s_axis_tuser[0] <= has_byte;
        s_axis_tlast    <= fin;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        if (has_byte || fin)
        begin
            words_sent++;
        end
    endtask

    // Hold input until every predicted tag word has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tags_pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic prepare_phase(input idle_mode_t mode, input logic [127:0] key,
                                 input logic [127:0] mask, input logic [4:0] len);
        drain_results();
        repeat (SETTLE) @(posedge clk);
        write_reg(REG_HASH_KEY_HIGH, key[127:64]);
        write_reg(REG_HASH_KEY_LOW, key[63:0]);
        write_reg(REG_MASK_HIGH, mask[127:64]);
        write_reg(REG_MASK_LOW, mask[63:0]);
        write_reg(REG_TAG_BYTES, {59'h0, len});
        cfg_we    <= 1'b0;
        idle_mode <= mode;
        @(posedge clk);
    endtask

    task automatic random_message();
        int len;
        int r;
        bit fin_has;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            len = 16 * $urandom_range(1, 3);
        end
        else if (r < 70)
        begin
            len = $urandom_range(0, 20);
        end
        else if (r < 95)
        begin
            len = $urandom_range(21, 64);
        end
        else
        begin
            len = $urandom_range(65, 200);
        end
        fin_has = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < len - int'(fin_has); k++)
        begin
            // empty word between bytes: data must be dropped
            if ($urandom_range(0, 99) < 8)
            begin
                send_word(8'($urandom), 1'b0, 1'b0);
            end
            send_word(8'($urandom), 1'b1, 1'b0);
        end
        send_word(8'($urandom), fin_has, 1'b1);
        messages++;
    endtask

    task automatic random_phase(input int quota);
        int target;
        target = words_sent + quota;
        while (words_sent < target)
        begin
            random_message();
            if ($urandom_range(0, 99) < 4)
            begin
                drain_results();
            end
        end
    endtask

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, byte on the final word, exact block, padded block
        prepare_phase(IDLE_NONE, rand128(), rand128(), 5'd16);
        send_word(8'hFF, 1'b0, 1'b1);
        messages++;
        send_word(8'hFF, 1'b1, 1'b1);
        messages++;
        for (int k = 0; k < 15; k++)
        begin
            send_word((k % 2 == 0) ? 8'h00 : 8'hFF, 1'b1, 1'b0);
            if (k == 7)
            begin
                send_word(8'hA5, 1'b0, 1'b0);
            end
        end
        send_word(8'h80, 1'b1, 1'b1);
        messages++;
        send_word(8'h01, 1'b1, 1'b0);
        send_word(8'h7F, 1'b1, 1'b0);
        send_word(8'h5A, 1'b0, 1'b1);
        messages++;

        prepare_phase(IDLE_NONE, rand128(), rand128(), 5'd4);
        random_phase(PHASE_QUOTA);
        prepare_phase(IDLE_TX, '0, rand128(), 5'd0);
        random_phase(PHASE_QUOTA);
        prepare_phase(IDLE_RX, '1, '1, 5'd31);
        random_phase(PHASE_QUOTA);
        prepare_phase(IDLE_BOTH, rand128(), '0, 5'd9);
        random_phase(PHASE_QUOTA);

        // Long output hold-off while input keeps coming, then a full pause
        prepare_phase(IDLE_NONE, rand128(), rand128(), 5'd8);
        hold_req <= 1'b1;
        random_phase(PHASE_QUOTA / 2);
        drain_results();
        random_phase(PHASE_QUOTA / 2);

        // Subkey equal to the field's unit element
        prepare_phase(IDLE_TX, {1'b1, 127'h0}, rand128(), 5'd3);
        random_phase(PHASE_QUOTA);
        prepare_phase(IDLE_BOTH, rand128(), rand128(), 5'd17);
        random_phase(PHASE_QUOTA);
        prepare_phase(IDLE_RX, rand128(), rand128(), 5'd15);
        random_phase(PHASE_QUOTA);

        drain_results();
        repeat (100) @(posedge clk);

        $display("Covered %0d messages (%0d input words), %0d tag words checked.",
                 messages, words_sent, words_checked);
        $display("Tag lengths 0 to 31 with clamping, zero/ones/unit subkeys, stalls, long hold.");
        if (fail_count == 0 && tags_pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/ggte_pkg.sv
src/gmac_ghash_tag_engine.sv
dv/gmac_tag_checker.sv
dv/tb_gmac_ghash_tag_engine.sv
